// ===== rtl/core/signed_decimal_alu_assert.svh =====
// ----------------------------------------------------------------------------
// signed_decimal_alu assertion macros
// Immediate-consequence and next-cycle property forms on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_ALU_ASSERT_SVH
`define SIGNED_DECIMAL_ALU_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define SDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define SDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sda_pkg.sv =====
// ----------------------------------------------------------------------------
// sda_pkg
// Shared constants, operation codes and types of the signed decimal ALU.
// ----------------------------------------------------------------------------
package sda_pkg;

    localparam int DIGITS_DEF = 16;
    localparam int BCD_W      = 64;
    localparam int MODE_W     = 3;

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CMP = 3'd4;

    typedef struct packed {
        logic sub;
    } unit_ctrl_t;

endpackage

// ===== rtl/core/sda_sanitize.sv =====
// ----------------------------------------------------------------------------
// sda_sanitize
// Keep the low DIGITS nibbles of a packed BCD word, clamping invalid digits to 9.
// ----------------------------------------------------------------------------
module sda_sanitize #(
    parameter int DIGITS = sda_pkg::DIGITS_DEF
) (
    input  logic [sda_pkg::BCD_W-1:0] raw,
    output logic [4*DIGITS-1:0]       mag
);

    for (genvar k = 0; k < DIGITS; k++)
    begin : g_digit
        assign mag[4*k +: 4] = (raw[4*k +: 4] > 4'd9) ? 4'd9 : raw[4*k +: 4];
    end

endmodule

// ===== rtl/core/sda_bcd_unit.sv =====
// ----------------------------------------------------------------------------
// sda_bcd_unit
// Shared BCD adder / ten's-complement subtractor over DIGITS+1 digits.
// ----------------------------------------------------------------------------
module sda_bcd_unit #(
    parameter int DIGITS = sda_pkg::DIGITS_DEF
) (
    input  logic [4*DIGITS+3:0]       x,
    input  logic [4*DIGITS+3:0]       y,
    input  sda_pkg::unit_ctrl_t       ctrl,
    output logic [4*DIGITS+3:0]       sum,
    output logic                      cout
);

    localparam int UW = 4 * DIGITS + 4;

    logic [UW-1:0] yy;
    logic [UW-1:0] six;
    logic [UW-1:0] corr;
    logic [UW:0]   t1;
    logic [UW:0]   t2;
    logic [UW:0]   cy;

    for (genvar k = 0; k < DIGITS + 1; k++)
    begin : g_digit
        assign yy[4*k +: 4]   = ctrl.sub ? (4'd9 - y[4*k +: 4]) : y[4*k +: 4];
        assign six[4*k +: 4]  = 4'h6;
        assign corr[4*k +: 4] = cy[4*k+4] ? 4'h0 : 4'h6;
    end

    assign t1   = {1'b0, x} + {1'b0, six};
    assign t2   = t1 + {1'b0, yy} + (UW+1)'(ctrl.sub);
    assign cy   = t2 ^ t1 ^ {1'b0, yy};
    assign sum  = t2[UW-1:0] - corr;
    assign cout = t2[UW];

endmodule

// ===== rtl/core/signed_decimal_alu.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_alu
// Sign-magnitude packed BCD add, subtract, multiply, divide and compare.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_stall stays high until its result is loaded
// into the output register. All work runs through one shared DIGITS+1 digit BCD
// adder, one add or subtract per cycle. Add and subtract take a compare step and
// an add step, compare only the compare step. Multiply takes each digit of b from
// the top, shifts the product and adds a once per unit of that digit; divide
// shifts each digit of a into the remainder, subtracting b until it borrows.
// ----------------------------------------------------------------------------
`include "signed_decimal_alu_assert.svh"

module signed_decimal_alu #(
    parameter int DIGITS = sda_pkg::DIGITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sda_pkg::MODE_W-1:0]  mode,
    input  logic                        a_negative,
    input  logic [sda_pkg::BCD_W-1:0]   a_bcd,
    input  logic                        b_negative,
    input  logic [sda_pkg::BCD_W-1:0]   b_bcd,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        r_negative,
    output logic [sda_pkg::BCD_W-1:0]   r_bcd,
    output logic                        is_less,
    output logic                        is_equal,
    output logic                        overflowed,
    output logic                        divide_by_zero
);

    localparam int W  = 4 * DIGITS;
    localparam int UW = W + 4;
    localparam int IW = $clog2(DIGITS);
    localparam int BW = sda_pkg::BCD_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(DIGITS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMP    = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_MSHIFT = 3'd3;
    localparam logic [2:0] S_MADD   = 3'd4;
    localparam logic [2:0] S_DSHIFT = 3'd5;
    localparam logic [2:0] S_DSUB   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [sda_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic                       sa_reg, sa_next;
    logic                       sb_reg, sb_next;
    logic [W-1:0]               ma_reg, ma_next;
    logic [W-1:0]               mb_reg, mb_next;
    logic [W-1:0]               sh_reg, sh_next;
    logic [UW-1:0]              acc_reg, acc_next;
    logic [W-1:0]               q_reg, q_next;
    logic [3:0]                 cnt_reg, cnt_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic                       ge_reg, ge_next;
    logic                       meq_reg, meq_next;
    logic                       ovf_reg, ovf_next;
    logic                       dz_reg, dz_next;
    logic                       rneg_reg, rneg_next;

    logic                       ov_reg, ov_next;
    logic                       rn_reg, rn_next;
    logic [BW-1:0]              rb_reg, rb_next;
    logic                       lt_reg, lt_next;
    logic                       eq_reg, eq_next;
    logic                       of_reg, of_next;
    logic                       z_reg, z_next;

    logic [W-1:0]               a_mag;
    logic [W-1:0]               b_mag;
    logic [UW-1:0]              ux;
    logic [UW-1:0]              uy;
    sda_pkg::unit_ctrl_t        uctrl;
    logic [UW-1:0]              usum;
    logic                       ucout;
    logic                       sbe;
    logic                       accept;
    logic                       load_out;

    sda_sanitize #(.DIGITS(DIGITS)) u_san_a (.raw(a_bcd), .mag(a_mag));
    sda_sanitize #(.DIGITS(DIGITS)) u_san_b (.raw(b_bcd), .mag(b_mag));

    sda_bcd_unit #(.DIGITS(DIGITS)) u_unit (
        .x    (ux),
        .y    (uy),
        .ctrl (uctrl),
        .sum  (usum),
        .cout (ucout)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == S_OUT) && (!ov_reg || !out_stall);
    assign sbe      = (mode_reg == sda_pkg::MODE_SUB) ? ((mb_reg != '0) && !sb_reg) : sb_reg;

    always_comb
    begin
        ux        = {4'h0, ma_reg};
        uy        = {4'h0, mb_reg};
        uctrl.sub = 1'b1;
        unique case (state_reg)
            S_ADD:
            begin
                if (sa_reg == sbe)
                begin
                    uctrl.sub = 1'b0;
                end
                else if (!ge_reg)
                begin
                    ux = {4'h0, mb_reg};
                    uy = {4'h0, ma_reg};
                end
            end
            S_MADD:
            begin
                ux        = acc_reg;
                uy        = {4'h0, ma_reg};
                uctrl.sub = 1'b0;
            end
            S_DSUB:
            begin
                ux = acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        sh_next    = sh_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        ge_next    = ge_reg;
        meq_next   = meq_reg;
        ovf_next   = ovf_reg;
        dz_next    = dz_reg;
        rneg_next  = rneg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = mode;
                    ma_next    = a_mag;
                    mb_next    = b_mag;
                    sa_next    = a_negative && (a_mag != '0);
                    sb_next    = b_negative && (b_mag != '0);
                    ovf_next   = 1'b0;
                    dz_next    = 1'b0;
                    rneg_next  = 1'b0;
                    q_next     = '0;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ge_next  = ucout;
                meq_next = (usum == '0);
                acc_next = '0;
                idx_next = LAST_IDX;
                unique case (mode_reg)
                    sda_pkg::MODE_ADD, sda_pkg::MODE_SUB:
                    begin
                        state_next = S_ADD;
                    end
                    sda_pkg::MODE_MUL:
                    begin
                        sh_next    = mb_reg;
                        state_next = S_MSHIFT;
                    end
                    sda_pkg::MODE_DIV:
                    begin
                        sh_next = ma_reg;
                        if (mb_reg == '0)
                        begin
                            dz_next    = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_DSHIFT;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_ADD:
            begin
                q_next     = usum[W-1:0];
                ovf_next   = (sa_reg == sbe) && (usum[UW-1:W] != '0);
                rneg_next  = ((sa_reg == sbe) || ge_reg) ? sa_reg : sbe;
                state_next = S_OUT;
            end
            S_MSHIFT:
            begin
                ovf_next   = ovf_reg || (acc_reg[W-1:W-4] != 4'h0);
                acc_next   = {4'h0, acc_reg[W-5:0], 4'h0};
                cnt_next   = sh_reg[W-1:W-4];
                sh_next    = {sh_reg[W-5:0], 4'h0};
                state_next = S_MADD;
            end
            S_MADD:
            begin
                if (cnt_reg != 4'd0)
                begin
                    acc_next = {4'h0, usum[W-1:0]};
                    ovf_next = ovf_reg || (usum[UW-1:W] != '0);
                    cnt_next = cnt_reg - 4'd1;
                end
                else if (idx_reg == '0)
                begin
                    q_next     = acc_reg[W-1:0];
                    rneg_next  = sa_reg ^ sb_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg - IW'(1);
                    state_next = S_MSHIFT;
                end
            end
            S_DSHIFT:
            begin
                acc_next   = {acc_reg[W-1:0], sh_reg[W-1:W-4]};
                sh_next    = {sh_reg[W-5:0], 4'h0};
                cnt_next   = 4'd0;
                state_next = S_DSUB;
            end
            S_DSUB:
            begin
                if (ucout)
                begin
                    acc_next = usum;
                    cnt_next = cnt_reg + 4'd1;
                end
                else
                begin
                    q_next = {q_reg[W-5:0], cnt_reg};
                    if (idx_reg == '0)
                    begin
                        rneg_next  = sa_reg ^ sb_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IW'(1);
                        state_next = S_DSHIFT;
                    end
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg && out_stall;
        rn_next = rn_reg;
        rb_next = rb_reg;
        lt_next = lt_reg;
        eq_next = eq_reg;
        of_next = of_reg;
        z_next  = z_reg;
        if (load_out)
        begin
            ov_next = 1'b1;
            rn_next = rneg_reg && (q_reg != '0);
            rb_next = BW'(q_reg);
            of_next = ovf_reg;
            z_next  = dz_reg;
            eq_next = (sa_reg == sb_reg) && meq_reg;
            if (sa_reg != sb_reg)
            begin
                lt_next = sa_reg;
            end
            else if (sa_reg)
            begin
                lt_next = ge_reg && !meq_reg;
            end
            else
            begin
                lt_next = !ge_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        ge_reg   <= ge_next;
        meq_reg  <= meq_next;
        ovf_reg  <= ovf_next;
        dz_reg   <= dz_next;
        rneg_reg <= rneg_next;
        rn_reg   <= rn_next;
        rb_reg   <= rb_next;
        lt_reg   <= lt_next;
        eq_reg   <= eq_next;
        of_reg   <= of_next;
        z_reg    <= z_next;
    end

    assign out_valid      = ov_reg;
    assign r_negative     = rn_reg;
    assign r_bcd          = rb_reg;
    assign is_less        = lt_reg;
    assign is_equal       = eq_reg;
    assign overflowed     = of_reg;
    assign divide_by_zero = z_reg;

    `SDA_ASSERT_NXT(a_accept_starts, accept, state_reg == S_CMP, "accepted word did not start")
    `SDA_ASSERT_IMP(a_neg_nonzero, out_valid && r_negative, r_bcd != '0, "negative zero result")
    `SDA_ASSERT_IMP(a_dz_clean, out_valid && divide_by_zero, (r_bcd == '0) && !overflowed,
        "divide by zero result not cleared")
    `SDA_ASSERT_IMP(a_cmp_excl, out_valid, !(is_less && is_equal), "less and equal both set")

endmodule
